/* sv/assert_macros.svh */
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/idtp_pkg.sv */
package idtp_pkg;

  localparam int CH_W      = 8;
  localparam int VAL_W     = 16;
  localparam int STS_W     = 3;
  localparam int MAG_W     = 17;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CNTR_W    = 5;

  // custom delimiter slots held in the two byte-packed registers
  localparam int DELIM_SLOTS = 16;

  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_MISSING   = 3'd1;
  localparam logic [STS_W-1:0] STS_TOO_LONG  = 3'd2;
  localparam logic [STS_W-1:0] STS_RANGE     = 3'd3;
  localparam logic [STS_W-1:0] STS_BAD_CHAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_DEFAULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH  = 2'd3;

  localparam logic [CH_W-1:0] DELIM_COLON  = 8'h3a;
  localparam logic [CH_W-1:0] DELIM_PERIOD = 8'h2e;
  localparam logic [CH_W-1:0] DELIM_SLASH  = 8'h2f;

  localparam logic [MAG_W-1:0] MAG_CAP = 17'h10000;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    logic            last;
  } in_item_t;

endpackage

/* sv/idtp_if.sv */
interface idtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface idtp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] site_value;
  logic [15:0] application_value;
  logic [15:0] entity_value;

  modport source (output valid, output status, output site_value,
                  output application_value, output entity_value, input ready);
  modport sink   (input valid, input status, input site_value,
                  input application_value, input entity_value, output ready);
endinterface

/* sv/idtp_in_reg.sv */
module idtp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  idtp_in_if.sink           in_bus,
  input  logic              advance,
  output idtp_pkg::in_item_t item
);
  import idtp_pkg::*;

  logic            valid_r, valid_nxt;
  logic [CH_W-1:0] ch_r;
  logic            last_r;
  logic            take;

  assign in_bus.ready = !valid_r || advance;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload holds until the next transaction
  always_ff @(posedge clk) begin
    if (take) begin
      ch_r   <= in_bus.ch;
      last_r <= in_bus.last;
    end
  end

  assign item.valid = valid_r;
  assign item.ch    = ch_r;
  assign item.last  = last_r;

endmodule

/* sv/idtp_delim.sv */
module idtp_delim (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [idtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [idtp_pkg::CFG_W-1:0]     cfg_data,
  input  logic [idtp_pkg::CH_W-1:0]      ch,
  output logic                          set_hit
);
  import idtp_pkg::*;

  logic              use_def_r;
  logic [CNTR_W-1:0] dcount_r;
  logic [CFG_W-1:0]  dlow_r;
  logic [CFG_W-1:0]  dhigh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_def_r <= 1'b1;
      dcount_r  <= '0;
      dlow_r    <= '0;
      dhigh_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_DEFAULT: use_def_r <= cfg_data[0];
        CFG_DELIM_COUNT: dcount_r  <= cfg_data[CNTR_W-1:0];
        CFG_CHARS_LOW:   dlow_r    <= cfg_data;
        CFG_CHARS_HIGH:  dhigh_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2*CFG_W-1:0] slots;
  logic [CNTR_W-1:0]  n_used;
  logic               custom_hit;
  logic               prefix_ok;
  logic [CH_W-1:0]    slot_ch;

  assign slots  = {dhigh_r, dlow_r};
  assign n_used = (dcount_r > CNTR_W'(DELIM_SLOTS)) ? CNTR_W'(DELIM_SLOTS) : dcount_r;

  // a zero byte ends the custom set: later slots never match
  always_comb begin
    custom_hit = 1'b0;
    prefix_ok  = 1'b1;
    slot_ch    = '0;
    for (int i = 0; i < DELIM_SLOTS; i++) begin
      slot_ch = slots[CH_W*i +: CH_W];
      if ((CNTR_W'(i) < n_used) && prefix_ok && (slot_ch == ch)) begin
        custom_hit = 1'b1;
      end
      prefix_ok = prefix_ok && (slot_ch != '0);
    end
  end

  assign set_hit = use_def_r ? ((ch == DELIM_COLON) || (ch == DELIM_PERIOD) ||
                                (ch == DELIM_SLASH))
                             : custom_hit;

endmodule

/* sv/idtp_parse.sv */
module idtp_parse #(
  parameter int MAX_CHARS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  idtp_pkg::in_item_t item,
  input  logic               set_hit,
  output logic               advance,
  idtp_out_if.source         out_bus
);
  import idtp_pkg::*;

  localparam int CNT_W = $clog2(MAX_CHARS + 2);
  localparam int SUM_W = MAG_W + 4;

  typedef enum logic [2:0] {
    PH_START, PH_SPACE, PH_SIGN, PH_ZERO, PH_HEXPFX, PH_DIGITS, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {RDX_8, RDX_10, RDX_16} radix_t;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       fidx_r, fidx_nxt;
  logic [CH_W-1:0]  delim_r, delim_nxt;
  phase_t           phase_r, phase_nxt;
  radix_t           radix_r, radix_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             stop_r, stop_nxt;
  logic [VAL_W-1:0] f0_r, f0_nxt;
  logic [VAL_W-1:0] f1_r, f1_nxt;
  logic [STS_W-1:0] err_r, err_nxt;
  logic             ended_r, ended_nxt;

  logic             out_valid_r;
  logic [STS_W-1:0] sts_r, sts_nxt;
  logic [VAL_W-1:0] site_r, site_nxt;
  logic [VAL_W-1:0] app_r, app_nxt;
  logic [VAL_W-1:0] ent_r, ent_nxt;

  logic [CH_W-1:0] ch;
  logic            is_space, is_dec, is_oct, is_nz, is_hex, digit_ok;
  logic [3:0]      dval;
  logic [SUM_W-1:0] mag_ext, scaled, sum;
  logic [MAG_W-1:0] mag_step;
  logic            delim_hit, value_ok_cur, value_ok_nxt, bad_end;
  logic            finish;

  assign ch = item.ch;

  // a result waits only for the final character of a string
  assign advance = item.valid && (!item.last || !out_valid_r || out_bus.ready);
  assign finish  = advance && item.last;

  always_comb begin
    is_space = (ch == 8'h20) || (ch inside {[8'h09:8'h0d]});
    is_dec   = ch inside {[8'h30:8'h39]};
    is_oct   = ch inside {[8'h30:8'h37]};
    is_nz    = ch inside {[8'h31:8'h39]};
    is_hex   = is_dec || (ch inside {[8'h41:8'h46]}) || (ch inside {[8'h61:8'h66]});
    dval     = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
    case (radix_r)
      RDX_8:   digit_ok = is_oct;
      RDX_10:  digit_ok = is_dec;
      RDX_16:  digit_ok = is_hex;
      default: digit_ok = 1'b0;
    endcase
  end

  // magnitude step with constant radix: shifts and adds, then saturate
  always_comb begin
    mag_ext = SUM_W'(mag_r);
    case (radix_r)
      RDX_8:   scaled = mag_ext << 3;
      RDX_10:  scaled = (mag_ext << 3) + (mag_ext << 1);
      RDX_16:  scaled = mag_ext << 4;
      default: scaled = mag_ext;
    endcase
    sum      = scaled + SUM_W'(dval);
    mag_step = (sum > SUM_W'(MAG_CAP)) ? MAG_CAP : sum[MAG_W-1:0];
  end

  assign delim_hit    = (fidx_r == 2'd0) ? set_hit : (ch == delim_r);
  assign value_ok_cur = !(neg_r && (mag_r != '0)) && !mag_r[MAG_W-1];
  assign bad_end      = !((phase_r == PH_START) || (phase_r == PH_ZERO) ||
                          (phase_r == PH_DIGITS));

  always_comb begin
    cnt_nxt   = (cnt_r <= CNT_W'(MAX_CHARS)) ? cnt_r + CNT_W'(1) : cnt_r;
    fidx_nxt  = fidx_r;
    delim_nxt = delim_r;
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    stop_nxt  = stop_r;
    f0_nxt    = f0_r;
    f1_nxt    = f1_r;
    err_nxt   = err_r;
    ended_nxt = ended_r;

    if (!ended_r && !stop_r) begin
      if (ch == '0) begin
        ended_nxt = 1'b1;
      end else if ((fidx_r < 2'd2) && delim_hit) begin
        if (!value_ok_cur) begin
          stop_nxt = 1'b1;
          err_nxt  = STS_RANGE;
        end else begin
          if (fidx_r == 2'd0) begin
            f0_nxt = mag_r[VAL_W-1:0];
          end else begin
            f1_nxt = mag_r[VAL_W-1:0];
          end
          if (bad_end) begin
            stop_nxt = 1'b1;
            err_nxt  = STS_BAD_CHAR;
          end else begin
            if (fidx_r == 2'd0) begin
              delim_nxt = ch;
            end
            fidx_nxt  = fidx_r + 2'd1;
            phase_nxt = PH_START;
            radix_nxt = RDX_10;
            mag_nxt   = '0;
            neg_nxt   = 1'b0;
          end
        end
      end else begin
        case (phase_r)
          PH_START, PH_SPACE: begin
            if (is_space) begin
              phase_nxt = PH_SPACE;
            end else if ((ch == 8'h2b) || (ch == 8'h2d)) begin
              neg_nxt   = (ch == 8'h2d);
              phase_nxt = PH_SIGN;
            end else if (ch == 8'h30) begin
              phase_nxt = PH_ZERO;
            end else if (is_nz) begin
              phase_nxt = PH_DIGITS;
              radix_nxt = RDX_10;
              mag_nxt   = MAG_W'(dval);
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_SIGN: begin
            if (ch == 8'h30) begin
              phase_nxt = PH_ZERO;
            end else if (is_nz) begin
              phase_nxt = PH_DIGITS;
              radix_nxt = RDX_10;
              mag_nxt   = MAG_W'(dval);
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_ZERO: begin
            if ((ch == 8'h78) || (ch == 8'h58)) begin
              phase_nxt = PH_HEXPFX;
            end else if (is_oct) begin
              phase_nxt = PH_DIGITS;
              radix_nxt = RDX_8;
              mag_nxt   = MAG_W'(dval);
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_HEXPFX: begin
            if (is_hex) begin
              phase_nxt = PH_DIGITS;
              radix_nxt = RDX_16;
              mag_nxt   = MAG_W'(dval);
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (digit_ok) begin
              mag_nxt = mag_step;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
    end
  end

  assign value_ok_nxt = !(neg_nxt && (mag_nxt != '0)) && !mag_nxt[MAG_W-1];

  always_comb begin
    sts_nxt  = STS_OK;
    site_nxt = f0_nxt;
    app_nxt  = f1_nxt;
    ent_nxt  = '0;
    if (cnt_nxt > CNT_W'(MAX_CHARS)) begin
      sts_nxt  = STS_TOO_LONG;
      site_nxt = '0;
      app_nxt  = '0;
    end else if (stop_nxt) begin
      sts_nxt = err_nxt;
    end else if (fidx_nxt < 2'd2) begin
      sts_nxt = STS_MISSING;
    end else if (!value_ok_nxt) begin
      sts_nxt = STS_RANGE;
    end else begin
      ent_nxt = mag_nxt[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      cnt_r   <= '0;
      fidx_r  <= '0;
      delim_r <= '0;
      phase_r <= PH_START;
      radix_r <= RDX_10;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      stop_r  <= 1'b0;
      f0_r    <= '0;
      f1_r    <= '0;
      err_r   <= '0;
      ended_r <= 1'b0;
    end else if (advance) begin
      cnt_r   <= cnt_nxt;
      fidx_r  <= fidx_nxt;
      delim_r <= delim_nxt;
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      stop_r  <= stop_nxt;
      f0_r    <= f0_nxt;
      f1_r    <= f1_nxt;
      err_r   <= err_nxt;
      ended_r <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sts_r  <= sts_nxt;
      site_r <= site_nxt;
      app_r  <= app_nxt;
      ent_r  <= ent_nxt;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.status            = sts_r;
  assign out_bus.site_value        = site_r;
  assign out_bus.application_value = app_r;
  assign out_bus.entity_value      = ent_r;

endmodule

/* sv/delimited_id_triple_parser.sv */
// channel  dir  handshake    payload
// in_bus   in   valid/ready  ch[7:0], last
// out_bus  out  valid/ready  status[2:0], site/application/entity_value[15:0]
// cfg      in   cfg_we       cfg_index[1:0], cfg_data[63:0]
//
// One character per cycle while no final character stalls; the input register
// holds each character until the parse state register takes its update.
// The output registers capture a result as its final character is taken.
// Only a final character stalls, and only while the previous result is not taken.
// Synchronous active-low reset clears the parse state and restores the
// default delimiter set.
module delimited_id_triple_parser #(
  parameter int MAX_CHARS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  idtp_in_if.sink                       in_bus,
  idtp_out_if.source                    out_bus,
  input  logic                          cfg_we,
  input  logic [idtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [idtp_pkg::CFG_W-1:0]     cfg_data
);
  import idtp_pkg::*;

  in_item_t item;
  logic     advance;
  logic     set_hit;

  idtp_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .advance (advance),
    .item    (item)
  );

  idtp_delim u_delim (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ch        (item.ch),
    .set_hit   (set_hit)
  );

  idtp_parse #(
    .MAX_CHARS (MAX_CHARS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .set_hit (set_hit),
    .advance (advance),
    .out_bus (out_bus)
  );

endmodule

/* sv/idtp_checker.sv */
`include "assert_macros.svh"

module idtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] site_value,
  input logic [15:0] application_value,
  input logic [15:0] entity_value
);
  import idtp_pkg::*;

  logic stalled;
  logic fields_zero;
  assign stalled     = out_valid && !out_ready;
  assign fields_zero = (site_value == '0) && (application_value == '0) &&
                       (entity_value == '0);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, stalled, $stable(status) && $stable(entity_value))
  `ASSERT_IMPLIES(a_long_zero, clk, rst_n, out_valid && (status == STS_TOO_LONG), fields_zero)
  `ASSERT_IMPLIES(a_err_no_entity, clk, rst_n, out_valid && (status != STS_OK), entity_value == '0)

endmodule

bind delimited_id_triple_parser idtp_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .status            (out_bus.status),
  .site_value        (out_bus.site_value),
  .application_value (out_bus.application_value),
  .entity_value      (out_bus.entity_value)
);

/* tb/testbench.sv */
module testbench;
  import idtp_pkg::*;

  localparam int MAX_CHARS = 64;

  typedef logic [CH_W-1:0] char_t;

  typedef enum logic [2:0] {
    NUM_START,
    NUM_SPACE,
    NUM_SIGN,
    NUM_ZERO,
    NUM_HEXPFX,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  typedef struct {
    logic [STS_W-1:0] status;
    logic [VAL_W-1:0] site;
    logic [VAL_W-1:0] app;
    logic [VAL_W-1:0] ent;
  } triple_t;

  class triple_scoreboard;
    bit            use_default;
    bit [4:0]      delim_count;
    bit [CFG_W-1:0] chars_lo;
    bit [CFG_W-1:0] chars_hi;

    int unsigned   char_count;
    int unsigned   field_idx;
    char_t         delim;
    num_phase_t    phase;
    int unsigned   radix;
    int unsigned   mag;
    bit            neg;
    bit            stopped;
    bit [VAL_W-1:0] site;
    bit [VAL_W-1:0] app;
    bit [STS_W-1:0] err;
    bit            ended;

    triple_t       expected_q[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   status_hits[5];

    function new();
      use_default = 1'b1;
      delim_count = '0;
      chars_lo = '0;
      chars_hi = '0;
      mismatches = 0;
      results_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      clear_parse();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_USE_DEFAULT: use_default = data[0];
        CFG_DELIM_COUNT: delim_count = data[4:0];
        CFG_CHARS_LOW:   chars_lo = data;
        CFG_CHARS_HIGH:  chars_hi = data;
        default: ;
      endcase
    endfunction

    function void clear_number();
      phase = NUM_START;
      radix = 10;
      mag = 0;
      neg = 1'b0;
    endfunction

    function void clear_parse();
      char_count = 0;
      field_idx = 0;
      delim = '0;
      stopped = 1'b0;
      site = '0;
      app = '0;
      err = '0;
      ended = 1'b0;
      clear_number();
    endfunction

    // delimiter candidates while the first field is open
    function void delim_set(ref char_t set[$]);
      int unsigned n;
      char_t d;
      set.delete();
      if (use_default) begin
        set.push_back(DELIM_COLON);
        set.push_back(DELIM_PERIOD);
        set.push_back(DELIM_SLASH);
        return;
      end
      n = (delim_count > DELIM_SLOTS) ? DELIM_SLOTS : delim_count;
      for (int unsigned i = 0; i < n; i++) begin
        d = (i < 8) ? chars_lo[8*i +: 8] : chars_hi[8*(i-8) +: 8];
        // a zero byte ends the custom set
        if (d == 8'h00) break;
        set.push_back(d);
      end
    endfunction

    function bit is_delim(char_t c);
      char_t set[$];
      if (field_idx != 0) return c == delim;
      delim_set(set);
      foreach (set[i]) if (set[i] == c) return 1'b1;
      return 1'b0;
    endfunction

    function int unsigned digit_val(char_t c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 99;
    endfunction

    function bit value_fits();
      return !((neg && mag != 0) || mag > 32'hffff);
    endfunction

    function void begin_digits(int unsigned r, int unsigned d);
      phase = NUM_DIGITS;
      radix = r;
      mag = d;
    endfunction

    function void advance_number(char_t c);
      int unsigned d;
      bit is_space;
      bit nonzero_dec;
      d = digit_val(c);
      is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
      nonzero_dec = (c >= "1" && c <= "9");
      case (phase)
        NUM_START, NUM_SPACE: begin
          if (is_space) phase = NUM_SPACE;
          else if (c == "+" || c == "-") begin
            neg = (c == "-");
            phase = NUM_SIGN;
          end else if (c == "0") phase = NUM_ZERO;
          else if (nonzero_dec) begin_digits(10, d);
          else phase = NUM_DONE;
        end
        NUM_SIGN: begin
          if (c == "0") phase = NUM_ZERO;
          else if (nonzero_dec) begin_digits(10, d);
          else phase = NUM_DONE;
        end
        NUM_ZERO: begin
          if (c == "x" || c == "X") phase = NUM_HEXPFX;
          else if (c >= "0" && c <= "7") begin_digits(8, d);
          else phase = NUM_DONE;
        end
        NUM_HEXPFX: begin
          if (d < 16) begin_digits(16, d);
          else phase = NUM_DONE;
        end
        NUM_DIGITS: begin
          if (d < radix) begin
            mag = mag * radix + d;
            if (mag > MAG_CAP) mag = MAG_CAP;
          end else begin
            phase = NUM_DONE;
          end
        end
        default: phase = NUM_DONE;
      endcase
    endfunction

    // range check first, then whether the number ended cleanly at the delimiter
    function void close_field(char_t c);
      bit unclean;
      unclean = (phase != NUM_START) && (phase != NUM_ZERO) && (phase != NUM_DIGITS);
      if (!value_fits()) begin
        stopped = 1'b1;
        err = STS_RANGE;
        return;
      end
      if (field_idx == 0) site = mag[VAL_W-1:0];
      else app = mag[VAL_W-1:0];
      if (unclean) begin
        stopped = 1'b1;
        err = STS_BAD_CHAR;
        return;
      end
      if (field_idx == 0) delim = c;
      field_idx++;
      clear_number();
    endfunction

    function void note_char(char_t c, bit fin);
      triple_t t;
      if (char_count <= MAX_CHARS) char_count++;
      if (!ended && !stopped) begin
        if (c == 8'h00) ended = 1'b1;
        else if (field_idx < 2 && is_delim(c)) close_field(c);
        else advance_number(c);
      end
      if (!fin) return;
      t.ent = '0;
      if (char_count > MAX_CHARS) begin
        t.status = STS_TOO_LONG;
        site = '0;
        app = '0;
      end else if (stopped) begin
        t.status = err;
      end else if (field_idx < 2) begin
        t.status = STS_MISSING;
      end else if (!value_fits()) begin
        t.status = STS_RANGE;
      end else begin
        t.status = STS_OK;
        t.ent = mag[VAL_W-1:0];
      end
      t.site = site;
      t.app = app;
      expected_q.push_back(t);
      clear_parse();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void complain(string what, triple_t want, triple_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d (status/site/app/ent)",
                 $realtime, what, want.status, want.site, want.app, want.ent,
                 got.status, got.site, got.app, got.ent);
    endfunction

    function void check_result(triple_t got);
      triple_t want;
      bit bad;
      results_seen++;
      if (expected_q.size() == 0) begin
        complain("unexpected result", got, got);
        return;
      end
      want = expected_q.pop_front();
      bad = 1'b0;
      if (got.status !== want.status) bad = 1'b1;
      if (got.site !== want.site) bad = 1'b1;
      if (got.app !== want.app) bad = 1'b1;
      if (got.ent !== want.ent) bad = 1'b1;
      if (bad) complain("result mismatch", want, got);
      if (want.status < 5) status_hits[want.status]++;
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  idtp_in_if  in_bus();
  idtp_out_if out_bus();

  delimited_id_triple_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  triple_scoreboard sb;
  char_t       delim_pool[$];
  bit          calm;
  int unsigned chars_sent;
  int unsigned strings_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    triple_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.status = out_bus.status;
      got.site = out_bus.site_value;
      got.app = out_bus.application_value;
      got.ent = out_bus.entity_value;
      sb.check_result(got);
    end
  end

  // result side: random stall before each transaction, none in calm stretches
  initial begin
    int unsigned stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  task automatic send_char(char_t c, bit fin);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.ch <= c;
    in_bus.last <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_char(c, fin);
    chars_sent++;
  endtask

  task automatic send_text(char_t t[$]);
    calm = ($urandom_range(0, 3) == 0);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
    strings_sent++;
  endtask

  function automatic void append_str(ref char_t t[$], input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  task automatic send_str(string s);
    char_t t[$];
    append_str(t, s);
    send_text(t);
  endtask

  // hold off until every result is back, then let the pipeline empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic set_delims(bit dflt, logic [4:0] count, logic [CFG_W-1:0] lo,
                            logic [CFG_W-1:0] hi);
    settle();
    write_reg(CFG_USE_DEFAULT, {{(CFG_W-1){1'b0}}, dflt});
    write_reg(CFG_DELIM_COUNT, {{(CFG_W-5){1'b0}}, count});
    write_reg(CFG_CHARS_LOW, lo);
    write_reg(CFG_CHARS_HIGH, hi);
    sb.delim_set(delim_pool);
  endtask

  function automatic void add_number(ref char_t t[$]);
    string s;
    int unsigned v;
    int unsigned r;
    int unsigned form;
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 5);
      t.push_back(r == 0 ? 8'h20 : 8'd8 + r[7:0]);
    end
    r = $urandom_range(0, 9);
    if (r == 0) t.push_back("+");
    else if (r == 1) t.push_back("-");
    r = $urandom_range(0, 19);
    if (r == 0) v = $urandom_range(65536, 300000);
    else if (r == 1) v = 0;
    else if (r == 2) v = 65535;
    else if (r < 10) v = $urandom_range(0, 999);
    else v = $urandom_range(0, 65535);
    form = $urandom_range(0, 9);
    if (form < 6) begin
      s = $sformatf("%0d", v);
    end else if (form < 8) begin
      s = $sformatf("%0h", v);
      if ($urandom_range(0, 1)) s = s.toupper();
      s = {($urandom_range(0, 1) ? "0x" : "0X"), s};
    end else if (form == 8) begin
      s = $sformatf("0%0o", v);
    end else begin
      s = "";
    end
    append_str(t, s);
  endfunction

  // mostly well-formed triples, some raw noise, a few strings past the length limit
  function automatic void build_triple(ref char_t t[$]);
    char_t d;
    int unsigned r;
    int unsigned target;
    t.delete();
    if ($urandom_range(0, 19) < 3) begin
      repeat ($urandom_range(1, 12)) t.push_back(char_t'($urandom_range(0, 255)));
    end else begin
      d = (delim_pool.size() != 0) ? delim_pool[$urandom_range(0, delim_pool.size() - 1)]
                                   : DELIM_COLON;
      add_number(t);
      if ($urandom_range(0, 15) != 0) t.push_back(d);
      add_number(t);
      r = $urandom_range(0, 15);
      if (r == 0 && delim_pool.size() != 0)
        t.push_back(delim_pool[$urandom_range(0, delim_pool.size() - 1)]);
      else if (r == 1) t.push_back(char_t'($urandom_range(0, 255)));
      else if (r != 2) t.push_back(d);
      add_number(t);
      r = $urandom_range(0, 5);
      if (r == 0) begin
        t.push_back(char_t'($urandom_range(0, 255)));
      end else if (r == 1) begin
        t.push_back(8'h00);
        repeat ($urandom_range(0, 3)) t.push_back(char_t'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 14) == 0) begin
      target = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 16);
      while (t.size() < target) t.push_back(char_t'($urandom_range(0, 255)));
    end
    if (t.size() == 0) t.push_back(8'h00);
  endfunction

  task automatic run_random(int unsigned n);
    char_t t[$];
    repeat (n) begin
      build_triple(t);
      send_text(t);
    end
  endtask

  task automatic send_padded(string s, int unsigned len);
    char_t t[$];
    append_str(t, s);
    while (t.size() < len) t.push_back(" ");
    send_text(t);
  endtask

  initial begin
    char_t t[$];
    sb = new();
    chars_sent = 0;
    strings_sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_USE_DEFAULT;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.ch = '0;
    in_bus.last = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    sb.delim_set(delim_pool);

    // default delimiters straight out of reset
    send_str("0x1F:-0:017");
    send_str("65535.0XfFfF.0");
    send_str("\t+9/010/ 42z");
    send_str("70000:1:1");
    send_str("1:-1:1");
    send_str("1:2:65536");
    send_str("1:2");
    send_str("7");
    send_str("+:1:1");
    send_str("0x:1:1");
    send_str("12a:1:1");
    send_str("::5");
    t.delete();
    append_str(t, "1:2:3");
    t.push_back(8'h00);
    append_str(t, "99");
    send_text(t);
    t.delete();
    t.push_back(8'h00);
    send_text(t);
    t.delete();
    append_str(t, "9:9:");
    t.push_back(8'hff);
    send_text(t);
    send_padded("1:2:3", MAX_CHARS);
    send_padded("1:2:3", MAX_CHARS + 1);

    run_random(1);
    settle();
    run_random(1);

    // three custom delimiters, one of them a digit
    set_delims(1'b0, 5'd3, 64'h0000_0000_003b_352c, 64'hffff_ffff_ffff_ffff);
    send_str("2553");
    send_str("15,2,3");
    run_random(2);

    // full custom set of sixteen, high-bit bytes included
    set_delims(1'b0, 5'd16, 64'h8040_2120_7e7c_5f23, 64'h7867_2625_3d7f_01ff);
    run_random(1);

    // empty custom set: nothing can close the first field
    set_delims(1'b0, 5'd0, 64'h0, 64'h0);
    run_random(1);

    // count above the slot limit, set cut short by a zero byte
    set_delims(1'b0, 5'd31, 64'h0000_0000_003b_2c2a, {$urandom, $urandom});
    run_random(1);

    // back to the default set with junk left in the custom registers
    set_delims(1'b1, 5'($urandom_range(0, 31)), {$urandom, $urandom}, {$urandom, $urandom});
    run_random(2);

    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d strings in %0d character transactions, checked %0d results.",
             strings_sent, chars_sent, sb.results_seen);
    $display("Status mix ok/missing/too long/range/bad char: %0d/%0d/%0d/%0d/%0d",
             sb.status_hits[STS_OK], sb.status_hits[STS_MISSING],
             sb.status_hits[STS_TOO_LONG], sb.status_hits[STS_RANGE],
             sb.status_hits[STS_BAD_CHAR]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* delimited_id_triple_parser.f */
+incdir+sv
sv/idtp_pkg.sv
sv/idtp_if.sv
sv/idtp_in_reg.sv
sv/idtp_delim.sv
sv/idtp_parse.sv
sv/delimited_id_triple_parser.sv
sv/idtp_checker.sv
tb/testbench.sv
